@@ design/tzds_pkg.sv @@
// Shared types, constants and calendar tables for the time zone shift block.
// Used by tzds_check and timezone_datetime_shift_top.
`default_nettype none
package tzds_pkg;

  localparam int unsigned MIN_PER_DAY = 1440;

  // All lengths below are in minutes.
  localparam logic [27:0] CENT_MIN      = 28'd52596000;
  localparam logic [25:0] QUAD_MIN      = 26'd2103840;
  localparam logic [25:0] YEAR_MIN      = 26'd525600;
  localparam logic [25:0] LEAP_YEAR_MIN = 26'd527040;
  localparam logic [25:0] DAY_MIN       = 26'd1440;
  localparam logic [25:0] HOUR_MIN      = 26'd60;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic        ok;
    logic [15:0] days;
    logic [10:0] tod;
  } chk_res_t;

  // Days before the first of a month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    if (mo == MONTH_FEB) begin
      r = leap ? 5'd29 : 5'd28;
    end else if (mo == MONTH_APR || mo == MONTH_JUN || mo == MONTH_SEP ||
                 mo == MONTH_NOV) begin
      r = 5'd30;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

  function automatic logic [25:0] month_minutes(input logic [3:0] mo, input logic leap);
    logic [25:0] r;
    unique case (month_days(mo, leap))
      5'd28:   r = 26'd40320;
      5'd29:   r = 26'd41760;
      5'd30:   r = 26'd43200;
      default: r = 26'd44640;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/timezone_datetime_shift_top.sv @@
// A rejected or flagged-invalid word goes from idle straight to the done state; an
// adjusted word first passes the calc, wrap, four-year block, year, month, day and hour
// states, stepping off one unit per compare. One word is in work at a time; the next is
// taken on the cycle after the result moves to the output register. The single compare
// and subtract unit serves every stepping state. Synchronous active-low reset clears the
// sequencer, the output handshake and the offset register (offset 0).
`default_nettype none
module timezone_datetime_shift_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_valid,
  input  logic [6:0]  in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_valid,
  output logic        out_adjusted,
  output logic [6:0]  out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds
);
  import tzds_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CALC = 4'd1;
  localparam logic [3:0] S_WRAP = 4'd2;
  localparam logic [3:0] S_QUAD = 4'd3;
  localparam logic [3:0] S_YEAR = 4'd4;
  localparam logic [3:0] S_MON  = 4'd5;
  localparam logic [3:0] S_DAY  = 4'd6;
  localparam logic [3:0] S_HOUR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;

  logic [15:0] days_r, days_nxt;
  logic [10:0] tod_r, tod_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic        vld_r, vld_nxt;
  logic        adj_r, adj_nxt;
  logic [6:0]  year_r, year_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  logic        o_vld_r, o_vld_nxt;
  logic        o_adj_r, o_adj_nxt;
  logic [6:0]  o_year_r, o_year_nxt;
  logic [3:0]  o_mon_r, o_mon_nxt;
  logic [4:0]  o_day_r, o_day_nxt;
  logic [4:0]  o_hour_r, o_hour_nxt;
  logic [5:0]  o_min_r, o_min_nxt;
  logic [5:0]  o_sec_r, o_sec_nxt;

  chk_res_t    chk;
  logic [25:0] len;
  logic        ge;
  logic [25:0] diff;
  logic [25:0] day_mins;
  logic        out_free;

  tzds_check u_check (
    .in_valid   (in_valid),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .in_hours   (in_hours),
    .in_minutes (in_minutes),
    .in_seconds (in_seconds),
    .res        (chk)
  );

  always_comb begin
    unique case (state_r)
      S_QUAD:  len = QUAD_MIN;
      S_YEAR:  len = (year_r[1:0] == 2'd0) ? LEAP_YEAR_MIN : YEAR_MIN;
      S_MON:   len = month_minutes(mon_r, year_r[1:0] == 2'd0);
      S_HOUR:  len = HOUR_MIN;
      default: len = DAY_MIN;
    endcase
  end

  tzds_sub_unit u_sub (
    .rem  (rem_r[25:0]),
    .len  (len),
    .ge   (ge),
    .diff (diff)
  );

  assign day_mins   = 26'(days_r) * 26'(MIN_PER_DAY);
  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    offset_nxt     = offset_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    days_nxt = days_r;  tod_nxt  = tod_r;  rem_nxt  = rem_r;
    vld_nxt  = vld_r;   adj_nxt  = adj_r;  year_nxt = year_r;
    mon_nxt  = mon_r;   day_nxt  = day_r;  hour_nxt = hour_r;
    min_nxt  = min_r;   sec_nxt  = sec_r;
    o_vld_nxt = o_vld_r;   o_adj_nxt  = o_adj_r;  o_year_nxt = o_year_r;
    o_mon_nxt = o_mon_r;   o_day_nxt  = o_day_r;  o_hour_nxt = o_hour_r;
    o_min_nxt = o_min_r;   o_sec_nxt  = o_sec_r;

    if (cfg_valid) begin
      offset_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          vld_nxt  = in_valid;
          adj_nxt  = chk.ok;
          days_nxt = chk.days;
          tod_nxt  = chk.tod;
          year_nxt = in_year;
          mon_nxt  = in_month;
          day_nxt  = in_day;
          hour_nxt = in_hours;
          min_nxt  = in_minutes;
          sec_nxt  = in_seconds;
          if (chk.ok) begin
            year_nxt  = 7'd0;
            mon_nxt   = 4'd1;
            day_nxt   = 5'd1;
            hour_nxt  = 5'd0;
            state_nxt = S_CALC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CALC: begin
        // Minutes since the start of year 0, shifted by the signed offset.
        rem_nxt   = {2'b00, day_mins} + {17'd0, tod_r} + {{12{offset_r[15]}}, offset_r};
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (rem_r[27]) begin
          rem_nxt = rem_r + CENT_MIN;
        end else if (rem_r >= CENT_MIN) begin
          rem_nxt = rem_r - CENT_MIN;
        end
        state_nxt = S_QUAD;
      end
      S_QUAD: begin
        if (ge) begin
          rem_nxt  = {2'b00, diff};
          year_nxt = year_r + 7'd4;
        end else begin
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ge) begin
          rem_nxt  = {2'b00, diff};
          year_nxt = year_r + 7'd1;
        end else begin
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        // December takes whatever is left.
        if (ge && mon_r != MONTH_DEC) begin
          rem_nxt = {2'b00, diff};
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        if (ge) begin
          rem_nxt = {2'b00, diff};
          day_nxt = day_r + 5'd1;
        end else begin
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        if (ge) begin
          rem_nxt  = {2'b00, diff};
          hour_nxt = hour_r + 5'd1;
        end else begin
          min_nxt   = rem_r[5:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          o_vld_nxt      = vld_r;
          o_adj_nxt      = adj_r;
          o_year_nxt     = year_r;
          o_mon_nxt      = mon_r;
          o_day_nxt      = day_r;
          o_hour_nxt     = hour_r;
          o_min_nxt      = min_r;
          o_sec_nxt      = sec_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      offset_r     <= 16'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      offset_r     <= offset_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;  tod_r  <= tod_nxt;  rem_r  <= rem_nxt;
    vld_r  <= vld_nxt;   adj_r  <= adj_nxt;  year_r <= year_nxt;
    mon_r  <= mon_nxt;   day_r  <= day_nxt;  hour_r <= hour_nxt;
    min_r  <= min_nxt;   sec_r  <= sec_nxt;
    o_vld_r  <= o_vld_nxt;   o_adj_r  <= o_adj_nxt;  o_year_r <= o_year_nxt;
    o_mon_r  <= o_mon_nxt;   o_day_r  <= o_day_nxt;  o_hour_r <= o_hour_nxt;
    o_min_r  <= o_min_nxt;   o_sec_r  <= o_sec_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_valid    = o_vld_r;
  assign out_adjusted = o_adj_r;
  assign out_year     = o_year_r;
  assign out_month    = o_mon_r;
  assign out_day      = o_day_r;
  assign out_hours    = o_hour_r;
  assign out_minutes  = o_min_r;
  assign out_seconds  = o_sec_r;

`ifndef SYNTHESIS
  // After the century wrap the remainder is a nonnegative minute count below one century.
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP) |=> (!rem_r[27] && rem_r < CENT_MIN))
    else $error("remainder out of century range after wrap");

  // Four-year blocks always start on a leap year.
  a_quad_align: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUAD) |-> (year_r[1:0] == 2'd0))
    else $error("year not aligned during block stepping");

  // Only a minute of the day can be left once the hour stepping starts.
  a_hour_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOUR) |-> (rem_r < {2'b00, DAY_MIN}))
    else $error("more than one day left at hour stepping");

  // A taken word always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CALC || state_r == S_DONE))
    else $error("accepted word did not start work");
`endif

endmodule
`default_nettype wire

@@ design/tzds_check.sv @@
// Range check of one UTC word and its day number and minute of day.
// Depends on tzds_pkg for the calendar tables and the result struct.
`default_nettype none
module tzds_check (
  input  logic              in_valid,
  input  logic [6:0]        in_year,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hours,
  input  logic [5:0]        in_minutes,
  input  logic [5:0]        in_seconds,
  output tzds_pkg::chk_res_t res
);
  import tzds_pkg::*;

  logic        leap;
  logic [15:0] year_days;
  logic [15:0] leap_days;
  logic        feb_fix;

  assign leap      = (in_year[1:0] == 2'd0);
  assign year_days = 16'(in_year) * 16'd365;
  assign leap_days = 16'((8'(in_year) + 8'd3) >> 2);
  assign feb_fix   = leap && (in_month > MONTH_FEB);

  always_comb begin
    res.ok = in_valid && (in_year <= 7'd99) && (in_month >= 4'd1) &&
             (in_month <= MONTH_DEC) && (in_day >= 5'd1) &&
             (in_day <= month_days(in_month, leap)) && (in_hours <= 5'd23) &&
             (in_minutes <= 6'd59) && (in_seconds <= 6'd59);
    res.days = year_days + leap_days + 16'(month_start(in_month)) +
               16'(in_day) - 16'd1 + 16'(feb_fix);
    res.tod  = 11'(in_hours) * 11'd60 + 11'(in_minutes);
  end

endmodule
`default_nettype wire

@@ design/tzds_sub_unit.sv @@
// Shared compare and subtract unit used by every stepping phase of the date rebuild.
// Depends on nothing beyond its ports.
`default_nettype none
module tzds_sub_unit (
  input  logic [25:0] rem,
  input  logic [25:0] len,
  output logic        ge,
  output logic [25:0] diff
);
  logic [26:0] wide;

  assign wide = {1'b0, rem} - {1'b0, len};
  assign ge   = !wide[26];
  assign diff = wide[25:0];

endmodule
`default_nettype wire
